// ===== sv/hdlc_pkg.sv =====
// Shared types, constants and the FCS byte update for the HDLC framer.
// No dependencies; every other file of the framer imports this package.
`timescale 1ns / 1ps
`default_nettype none

package hdlc_pkg;

  // Configuration register indexes.
  localparam logic REG_FLAG  = 1'b0;
  localparam logic REG_STUFF = 1'b1;

  // Word kinds on the input side.
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

  // Register reset values.
  localparam logic [7:0] FLAG_RESET  = 8'h7E;
  localparam logic [2:0] STUFF_RESET = 3'd5;

  // FCS: reflected 0x1021 polynomial, init 0xFFFF.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  // Most line bits one input word may produce.
  localparam int MAX_RESULTS = 64;

  // Entries in the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // One classified word on its way from the front to the back.
  typedef struct packed {
    logic        pre;      // send the preamble first
    logic        close;    // payload is the FCS, closing flag follows
    logic [15:0] payload;  // data byte in the low bits, or the FCS
  } hdlc_item_t;

  // Configuration seen by the serializer.
  typedef struct packed {
    logic [7:0] flag;
    logic [2:0] stuff_run;
  } hdlc_cfg_t;

  // One byte through the FCS register, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] octet);
    logic [15:0] c;
    c = crc ^ {8'h00, octet};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/hdlc_bit_stuffing_framer.sv =====
// Channel   | Dir | Signals                          | Word
// in_       | in  | tvalid tready tdata[7:0] tuser   | one packet byte or a close
// out_      | out | tvalid tready tdata[7:0] tlast tuser | one line bit
// cfg_      | in  | wr_en index wr_data[7:0]         | register write
//
// A data byte produces 8 to 16 line bits, one per unstalled cycle; the first of a
// packet adds the preamble (RAMP_BITS + TRAINING_BITS + 8 bits). A close
// produces 24 to 40 bits. The serializer sets the rate: one bit per cycle unless the output stalls.
// A two-entry queue lets the front take bytes while the serializer works.
// Reset is synchronous and active low; no clearing pass is needed.
// A stall on the output holds the serializer, then the queue, then in_tready.
// Top level of the HDLC framer; uses hdlc_pkg, hdlc_front, hdlc_queue, hdlc_back.
`timescale 1ns / 1ps
`default_nettype none

module hdlc_bit_stuffing_framer
  import hdlc_pkg::*;
#(
  parameter int RAMP_BITS     = 8,
  parameter int TRAINING_BITS = 24
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic [0:0] in_tuser,   // [0] kind
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [0] line_bit, [7:1] zero
  output logic            out_tlast,  // run_last
  output logic [0:0]      out_tuser,  // [0] packet_end
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wr_data
);

  hdlc_cfg_t  cfg_r;
  hdlc_item_t f_item, q_item;
  logic       q_push, q_full, q_valid, q_pop;
  logic       front_in_pkt, back_busy;
  logic       line_bit;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag      <= FLAG_RESET;
      cfg_r.stuff_run <= STUFF_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FLAG:  cfg_r.flag      <= cfg_wr_data;
        REG_STUFF: cfg_r.stuff_run <= cfg_wr_data[2:0];
        default:   cfg_r           <= cfg_r;
      endcase
    end
  end

  hdlc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_data_byte (in_tdata),
    .in_kind      (in_tuser[0]),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (f_item),
    .in_pkt       (front_in_pkt)
  );

  hdlc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (f_item),
    .full      (q_full),
    .valid     (q_valid),
    .pop       (q_pop),
    .pop_item  (q_item)
  );

  hdlc_back #(
    .RAMP_BITS     (RAMP_BITS),
    .TRAINING_BITS (TRAINING_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .busy       (back_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_bit    (line_bit),
    .out_last   (out_tlast),
    .out_end    (out_tuser[0])
  );

  assign out_tdata = {7'b0, line_bit};

  // The closing flag's final bit always ends its word.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("packet end without word end");

  // A close leaves the front outside a packet.
  a_close_ends_pkt: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == KIND_CLOSE) |=> !front_in_pkt)
    else $error("close did not end packet");

  // An idle serializer picks up a waiting item at once.
  a_idle_pickup: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && !back_busy |=> back_busy)
    else $error("serializer missed a queued item");

endmodule

`default_nettype wire

// ===== sv/hdlc_front.sv =====
// Front end of the HDLC framer: accepts input words, tracks packet state
// and the running FCS, and pushes classified items. Uses hdlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hdlc_front
  import hdlc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_kind,
  input  wire logic       q_full,
  output logic            q_push,
  output hdlc_item_t      q_item,
  output logic            in_pkt
);

  logic [15:0] crc_r, crc_nxt;
  logic        in_pkt_r, in_pkt_nxt;
  logic [15:0] crc_base;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;
  assign in_pkt    = in_pkt_r;

  // A new packet restarts the FCS before its first byte.
  assign crc_base = in_pkt_r ? crc_r : CRC_INIT;

  // Classify the word and advance the FCS.
  always_comb begin
    q_item.pre     = !in_pkt_r;
    q_item.close   = (in_kind == KIND_CLOSE);
    q_item.payload = {8'h00, in_data_byte};
    crc_nxt        = crc_r;
    in_pkt_nxt     = in_pkt_r;
    if (in_kind == KIND_CLOSE) begin
      q_item.payload = ~crc_base;
      if (q_push) begin
        crc_nxt    = CRC_INIT;
        in_pkt_nxt = 1'b0;
      end
    end else if (q_push) begin
      crc_nxt    = crc_byte(crc_base, in_data_byte);
      in_pkt_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= CRC_INIT;
      in_pkt_r <= 1'b0;
    end else begin
      crc_r    <= crc_nxt;
      in_pkt_r <= in_pkt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/hdlc_queue.sv =====
// Two-entry queue that decouples the HDLC front end from the serializer.
// Uses hdlc_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none

module hdlc_queue
  import hdlc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire hdlc_item_t push_item,
  output logic            full,
  output logic            valid,
  input  wire logic       pop,
  output hdlc_item_t      pop_item
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  hdlc_item_t            mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]       count_r;

  assign full     = (count_r == CntW'(QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_item = mem_r[rd_ptr_r];

  // Storage is written without reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/hdlc_back.sv =====
// Serializer of the HDLC framer: preamble, stuffed payload, closing flag,
// one line bit per cycle, unless the output stalls, into an output register. Uses hdlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hdlc_back
  import hdlc_pkg::*;
#(
  parameter int RAMP_BITS     = 8,
  parameter int TRAINING_BITS = 24
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire hdlc_cfg_t  cfg,
  input  wire logic       q_valid,
  input  wire hdlc_item_t q_item,
  output logic            q_pop,
  output logic            busy,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic            out_bit,
  output logic            out_last,
  output logic            out_end
);

  localparam int CntMax = (TRAINING_BITS > 16) ? TRAINING_BITS : 16;
  localparam int CntW   = $clog2(CntMax + 1);
  localparam int OcntW  = $clog2(MAX_RESULTS);

  typedef enum logic [2:0] {
    PH_RAMP,
    PH_TRAIN,
    PH_OPEN,
    PH_DATA,
    PH_CLOSE
  } phase_t;

  phase_t            ph_r, ph_nxt, ph_start;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [2:0]        ones_r, ones_nxt, ones_upd;
  logic              pend_r, pend_nxt;
  logic              busy_r;
  logic              trunc_r;
  logic [OcntW-1:0]  ocnt_r;
  hdlc_item_t        item_r;
  logic              out_vld_r, out_bit_r, out_last_r, out_end_r;

  logic step, push, bit_v, nat_last, end_v, data_bit, cap_last;

  assign busy       = busy_r;
  assign out_tvalid = out_vld_r;
  assign out_bit    = out_bit_r;
  assign out_last   = out_last_r;
  assign out_end    = out_end_r;

  // Advance whenever the output register is free or being drained.
  assign step     = busy_r && (!out_vld_r || out_tready);
  assign push     = step && !trunc_r;
  assign cap_last = (ocnt_r == OcntW'(MAX_RESULTS - 1));
  assign q_pop    = q_valid && (!busy_r || (step && nat_last));
  assign data_bit = item_r.payload[cnt_r[3:0]];
  assign ones_upd = data_bit ? ((ones_r == 3'd7) ? 3'd7 : ones_r + 3'd1) : 3'd0;

  always_comb begin
    if (!q_item.pre) begin
      ph_start = PH_DATA;
    end else if (RAMP_BITS > 0) begin
      ph_start = PH_RAMP;
    end else begin
      ph_start = PH_TRAIN;
    end
  end

  // One line bit per step; steps past MAX_RESULTS bits of a word emit nothing.
  always_comb begin
    ph_nxt   = ph_r;
    cnt_nxt  = cnt_r + 1'b1;
    ones_nxt = ones_r;
    pend_nxt = pend_r;
    bit_v    = 1'b0;
    nat_last = 1'b0;
    end_v    = 1'b0;
    case (ph_r)
      PH_RAMP: begin
        bit_v = 1'b1;
        if (cnt_r == CntW'(RAMP_BITS - 1)) begin
          ph_nxt  = PH_TRAIN;
          cnt_nxt = '0;
        end
      end
      PH_TRAIN: begin
        bit_v = cnt_r[0];
        if (cnt_r == CntW'(TRAINING_BITS - 1)) begin
          ph_nxt  = PH_OPEN;
          cnt_nxt = '0;
        end
      end
      PH_OPEN: begin
        bit_v = cfg.flag[cnt_r[2:0]];
        if (cnt_r == CntW'(7)) begin
          ph_nxt   = PH_DATA;
          cnt_nxt  = '0;
          ones_nxt = 3'd0;
          pend_nxt = 1'b0;
        end
      end
      PH_DATA: begin
        if (pend_r) begin
          // Inserted zero once the ones count has reached the stuff length.
          bit_v    = 1'b0;
          pend_nxt = 1'b0;
          ones_nxt = 3'd0;
          cnt_nxt  = cnt_r;
          if (cnt_r == (item_r.close ? CntW'(16) : CntW'(8))) begin
            if (item_r.close) begin
              ph_nxt  = PH_CLOSE;
              cnt_nxt = '0;
            end else begin
              nat_last = 1'b1;
            end
          end
        end else begin
          bit_v = data_bit;
          if (ones_upd == cfg.stuff_run) begin
            pend_nxt = 1'b1;
            ones_nxt = 3'd0;
          end else begin
            ones_nxt = ones_upd;
            if (cnt_r == (item_r.close ? CntW'(15) : CntW'(7))) begin
              if (item_r.close) begin
                ph_nxt  = PH_CLOSE;
                cnt_nxt = '0;
              end else begin
                nat_last = 1'b1;
              end
            end
          end
        end
      end
      PH_CLOSE: begin
        bit_v = cfg.flag[cnt_r[2:0]];
        if (cnt_r == CntW'(7)) begin
          nat_last = 1'b1;
          end_v    = 1'b1;
          ones_nxt = 3'd0;
        end
      end
      default: begin
        nat_last = 1'b1;
      end
    endcase
  end

  // Sequencer state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r      <= PH_DATA;
      cnt_r     <= '0;
      ones_r    <= 3'd0;
      pend_r    <= 1'b0;
      busy_r    <= 1'b0;
      trunc_r   <= 1'b0;
      ocnt_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (step) begin
        ones_r <= ones_nxt;
      end
      if (q_pop) begin
        item_r  <= q_item;
        ph_r    <= ph_start;
        cnt_r   <= '0;
        pend_r  <= 1'b0;
        trunc_r <= 1'b0;
        ocnt_r  <= '0;
        busy_r  <= 1'b1;
      end else if (step) begin
        ph_r   <= ph_nxt;
        cnt_r  <= cnt_nxt;
        pend_r <= pend_nxt;
        if (push) begin
          ocnt_r <= ocnt_r + 1'b1;
          if (cap_last) begin
            trunc_r <= 1'b1;
          end
        end
        if (nat_last) begin
          busy_r <= 1'b0;
        end
      end
      if (push) begin
        out_vld_r  <= 1'b1;
        out_bit_r  <= bit_v;
        out_last_r <= nat_last || cap_last;
        out_end_r  <= end_v;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== dv/hdlc_framer_checker.sv =====
// Checker for the HDLC bit-stuffing framer: watches the byte, line and register ports,
// predicts every line bit from the accepted words and compares field by field.
// Depends on hdlc_pkg for register indexes, word kinds and FCS constants.
`timescale 1ns / 1ps

module hdlc_framer_checker
  import hdlc_pkg::*;
#(
  parameter int RAMP_BITS     = 8,
  parameter int TRAINING_BITS = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] data_byte
  input  logic [0:0] in_tuser,    // [0] kind
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,   // [0] line_bit, [7:1] zero
  input  logic       out_tlast,   // run_last
  input  logic [0:0] out_tuser,   // [0] packet_end
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wr_data,
  output int         fail_count,
  output int         pending
);

  // One predicted line bit with its markers.
  typedef struct packed {
    logic lbit;
    logic last;
    logic closing;
  } line_bit_t;

  // Register copies and framer state as the line should see them.
  logic [7:0]  flag_octet;
  logic [2:0]  stuff_len;
  logic [15:0] fcs_reg;
  logic [2:0]  ones_seen;
  logic        framing;
  int          bits_this_word;
  line_bit_t   bits_due[$];

  // FCS update, one data bit at a time, LSB first.
  function automatic logic [15:0] fcs_step(input logic [15:0] acc, input logic [7:0] octet);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ octet[i];
      acc = acc >> 1;
      if (fb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  // Bits past the per-word limit are dropped; state still moves on.
  task automatic queue_bit(input logic lb, input logic ce);
    if (bits_this_word < MAX_RESULTS) begin
      bits_due.insert(bits_due.size(), line_bit_t'{lbit: lb, last: 1'b0, closing: ce});
      bits_this_word++;
    end
  endtask

  task automatic queue_flag(input logic closing);
    for (int b = 0; b < 8; b++) queue_bit(flag_octet[b], closing && (b == 7));
  endtask

  task automatic queue_preamble();
    for (int i = 0; i < RAMP_BITS; i++) queue_bit(1'b1, 1'b0);
    for (int i = 0; i < TRAINING_BITS; i++) queue_bit(i[0], 1'b0);
    queue_flag(1'b0);
    fcs_reg   = CRC_INIT;
    ones_seen = '0;
    framing   = 1'b1;
  endtask

  // A zero goes in whenever the ones count matches the stuff length, which
  // after a zero bit also holds for a stuff length of zero.
  task automatic queue_stuffed(input logic [7:0] octet);
    for (int b = 0; b < 8; b++) begin
      queue_bit(octet[b], 1'b0);
      if (octet[b]) begin
        if (ones_seen != 3'd7) ones_seen++;
      end else begin
        ones_seen = '0;
      end
      if (ones_seen == stuff_len) begin
        queue_bit(1'b0, 1'b0);
        ones_seen = '0;
      end
    end
  endtask

  // Works out every line bit that one accepted word causes.
  task automatic frame_word(input logic kind, input logic [7:0] octet);
    logic [15:0] fcs;
    bits_this_word = 0;
    if (!framing) queue_preamble();
    if (kind == KIND_DATA) begin
      fcs_reg = fcs_step(fcs_reg, octet);
      queue_stuffed(octet);
    end else begin
      fcs = ~fcs_reg;
      queue_stuffed(fcs[7:0]);
      queue_stuffed(fcs[15:8]);
      queue_flag(1'b1);
      fcs_reg   = CRC_INIT;
      ones_seen = '0;
      framing   = 1'b0;
    end
    if (bits_this_word > 0) bits_due[bits_due.size() - 1].last = 1'b1;
  endtask

  // Everything is sampled at the rising edge, before the framer updates.
  always @(posedge clk) begin : watch_ports
    line_bit_t want;
    if (!rst_n) begin
      flag_octet = FLAG_RESET;
      stuff_len  = STUFF_RESET;
      fcs_reg    = CRC_INIT;
      ones_seen  = '0;
      framing    = 1'b0;
      bits_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FLAG:  flag_octet = cfg_wr_data;
          REG_STUFF: stuff_len  = cfg_wr_data[2:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) frame_word(in_tuser[0], in_tdata);
      if (out_tvalid && out_tready) begin
        if (bits_due.size() == 0) begin
          $error("line_bit: expected nothing, got %0h", out_tdata);
          fail_count++;
        end else begin
          want = bits_due.pop_front();
          if (out_tdata !== {7'd0, want.lbit}) begin
            $error("line_bit: expected %0h, got %0h", {7'd0, want.lbit}, out_tdata);
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $error("run_last: expected %0b, got %0b", want.last, out_tlast);
            fail_count++;
          end
          if (out_tuser[0] !== want.closing) begin
            $error("packet_end: expected %0b, got %0b", want.closing, out_tuser[0]);
            fail_count++;
          end
        end
      end
    end
    pending = bits_due.size();
  end

endmodule

// ===== dv/tb_hdlc_bit_stuffing_framer.sv =====
// Top of the HDLC framer testbench: clock, reset, register writes, packet stimulus
// and line-side stalls. Depends on hdlc_pkg, the framer RTL and hdlc_framer_checker.
`timescale 1ns / 1ps

module tb_hdlc_bit_stuffing_framer;
  import hdlc_pkg::*;

  localparam int RAMP   = 8;
  localparam int TRAIN  = 24;
  localparam int RANDOM_WORDS = 100;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] data_byte
  logic [0:0] in_tuser;   // [0] kind
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [0] line_bit, [7:1] zero
  logic       out_tlast;  // run_last
  logic [0:0] out_tuser;  // [0] packet_end
  logic       cfg_wr_en;
  logic       cfg_index;
  logic [7:0] cfg_wr_data;

  int fail_count;
  int pending;
  int words_sent;
  bit in_idles;
  bit out_stalls;

  hdlc_bit_stuffing_framer #(
    .RAMP_BITS    (RAMP),
    .TRAINING_BITS(TRAIN)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  hdlc_framer_checker #(
    .RAMP_BITS    (RAMP),
    .TRAINING_BITS(TRAIN)
  ) line_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle cycles before a word: mostly none or a few, now and then a long pause.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!in_idles || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Payloads lean toward runs of ones so that stuffing happens often.
  function automatic logic [7:0] payload_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 8'hFF;
    if (r == 3) return 8'h7E;
    return 8'($urandom_range(0, 255));
  endfunction

  // Offers one word and returns at the falling edge after it was taken.
  task automatic put_word(input logic kind, input logic [7:0] octet);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      in_tdata  = 8'($urandom_range(0, 255));
      in_tuser  = 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = octet;
    in_tuser  = kind;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    @(negedge clk);
  endtask

  // Waits until every predicted line bit has come out.
  task automatic drain();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic index, input logic [7:0] value);
    cfg_wr_en   = 1'b1;
    cfg_index   = index;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  task automatic set_framing(input logic [7:0] flag, input logic [2:0] run_len);
    write_reg(REG_FLAG, flag);
    write_reg(REG_STUFF, {5'd0, run_len});
  endtask

  task automatic send_packet(input int len);
    for (int i = 0; i < len; i++) put_word(KIND_DATA, payload_byte());
    put_word(KIND_CLOSE, 8'($urandom_range(0, 255)));
  endtask

  // Line-side stalls: runs of ready broken by stalls, mostly short.
  initial begin : stall_gen
    int run;
    int r;
    out_tready = 1'b0;
    forever begin
      if (!out_stalls) begin
        out_tready = 1'b1;
        @(negedge clk);
      end else begin
        out_tready = 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
        r = $urandom_range(0, 99);
        if (r < 70) run = $urandom_range(1, 2);
        else if (r < 95) run = $urandom_range(3, 6);
        else run = $urandom_range(15, 40);
        out_tready = 1'b0;
        repeat (run) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int len;
    int r;
    logic [2:0] run_len;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_wr_en   = 1'b0;
    cfg_index   = REG_FLAG;
    cfg_wr_data = '0;
    in_idles    = 1'b0;
    out_stalls  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings, no idling: a close with no data, then ones runs around
    // the stuff length and a byte shaped like the flag.
    put_word(KIND_CLOSE, 8'hA5);
    put_word(KIND_DATA, 8'h00);
    put_word(KIND_DATA, 8'hFF);
    put_word(KIND_DATA, 8'hFF);
    put_word(KIND_DATA, 8'h7E);
    put_word(KIND_DATA, 8'h3E);
    put_word(KIND_DATA, 8'hAA);
    put_word(KIND_CLOSE, 8'hFF);
    drain();

    // Longest stuff length with an all-zero flag.
    in_idles   = 1'b1;
    out_stalls = 1'b1;
    set_framing(8'h00, 3'd7);
    put_word(KIND_DATA, 8'hFF);
    put_word(KIND_DATA, 8'hFF);
    put_word(KIND_DATA, 8'h80);
    put_word(KIND_CLOSE, 8'h00);
    drain();

    // Stuff length zero: ones saturate and every zero gets a zero after it.
    set_framing(8'hFF, 3'd0);
    put_word(KIND_DATA, 8'hFF);
    put_word(KIND_DATA, 8'hFF);
    put_word(KIND_CLOSE, 8'h5A);
    put_word(KIND_CLOSE, 8'h00);
    drain();

    // Stuff length one, then a short run of four.
    set_framing(8'h81, 3'd1);
    put_word(KIND_DATA, 8'h01);
    put_word(KIND_DATA, 8'hFF);
    put_word(KIND_CLOSE, 8'h00);
    drain();
    set_framing(8'h55, 3'd4);
    put_word(KIND_CLOSE, 8'h3C);
    drain();

    // Random settings, each phase a few packets of random length.
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      r = $urandom_range(0, 9);
      run_len    = (r < 6) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      set_framing(8'($urandom_range(0, 255)), run_len);
      in_idles   = $urandom_range(0, 3) != 0;
      out_stalls = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(1, 3)) begin
        r = $urandom_range(0, 99);
        if (r < 10) len = 0;
        else if (r < 85) len = $urandom_range(1, 6);
        else len = $urandom_range(10, 20);
        send_packet(len);
      end
      drain();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_hdlc_bit_stuffing_framer: clean");
    end else begin
      $display("tb_hdlc_bit_stuffing_framer: errors");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("tb_hdlc_bit_stuffing_framer: errors");
    $finish;
  end

endmodule
